// File: rtl/core/kmp_substring_matcher_defines.svh
// ----------------------------------------------------------------------------
// kmp_substring_matcher_defines
// Assertion macros used by the checker file of the matcher.
// ----------------------------------------------------------------------------
`ifndef KMP_SUBSTRING_MATCHER_DEFINES_SVH
`define KMP_SUBSTRING_MATCHER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KMP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KMP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/kmp_pkg.sv
// ----------------------------------------------------------------------------
// kmp_pkg
// Types, sizes and codes shared by the substring matcher modules.
// ----------------------------------------------------------------------------
package kmp_pkg;

    // Longest pattern the store holds.
    localparam int MAX_PATTERN = 256;
    // Lengths run from 0 to MAX_PATTERN inclusive.
    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    // Index into the pattern store.
    localparam int SW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    localparam logic CMD_PATTERN = 1'b0;
    localparam logic CMD_TEXT    = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] ch;
        logic       first;
    } t_in_item;

    typedef struct packed {
        logic             found;
        logic [LEN_W-1:0] matched_len;
        logic             too_long;
    } t_out_item;

    // Controller to datapath.
    typedef struct packed {
        logic accept;
        logic seed;
        logic step;
        logic finish;
        logic emit;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic early;
        logic cont;
        logic out_free;
    } t_dp_status;

endpackage

// File: rtl/core/kmp_substring_matcher.sv
// ----------------------------------------------------------------------------
// kmp_substring_matcher
// Knuth-Morris-Pratt substring matcher with an incrementally built link table.
// ----------------------------------------------------------------------------
// Load a pattern one byte per request (cmd = pattern, first = 1 on its first
// byte), then stream text bytes (first = 1 on the first byte of each text).
// Every request returns exactly one result: a sticky found flag, the pattern
// length (pattern requests) or current matched prefix length (text requests),
// and a too-long flag once the pattern outgrows its MAX_PATTERN-byte store.
// The block takes one request at a time. A request that needs no link walk
// (a full store, the first pattern byte, or any text byte with an empty
// pattern) goes from accept straight to the hand-off. Any other pattern
// byte first fetches its starting link, while any other text byte starts
// the walk at once; the walk follows its k failure links, one per cycle,
// through the single registered read port of the pattern store and
// link table. Over a stream k averages about one per byte. A finished result
// waits in an output register, so the next request is accepted while the
// previous result is still stalled; only the hand-off into that register waits.
// ----------------------------------------------------------------------------
module kmp_substring_matcher (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  kmp_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output kmp_pkg::t_out_item o_out_data
);
    import kmp_pkg::*;

    // Command and status between sequencer and datapath.
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // Sequencer: accept, seed the link walk, walk, hand off.
    kmp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    // Datapath: pattern store, link table, match state, result register.
    kmp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// File: rtl/core/kmp_ctrl.sv
// ----------------------------------------------------------------------------
// kmp_ctrl
// Sequencer: accept a request, walk failure links, hand off the result.
// ----------------------------------------------------------------------------
module kmp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  kmp_pkg::t_dp_status i_status,
    output kmp_pkg::t_dp_cmd    o_cmd
);
    import kmp_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SEED  = 2'd1;
    localparam logic [1:0] S_WALK  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_WALK;
                    if (i_status.early) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SEED: begin
                o_cmd.seed = 1'b1;
                n_state    = S_WALK;
            end
            S_WALK: begin
                if (i_status.cont) begin
                    o_cmd.step = 1'b1;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Pattern bytes that go on to a link walk need one extra read to fetch the starting link.
    logic seed_needed;
    assign seed_needed = o_cmd.accept && !i_status.early && i_status.cont;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else if (seed_needed) begin
            r_state <= S_SEED;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// File: rtl/core/kmp_dp.sv
// ----------------------------------------------------------------------------
// kmp_dp
// Pattern store, failure table, match state and result register.
// ----------------------------------------------------------------------------
module kmp_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kmp_pkg::t_in_item   i_in_data,
    input  kmp_pkg::t_dp_cmd    i_cmd,
    output kmp_pkg::t_dp_status o_status,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output kmp_pkg::t_out_item  o_out_data
);
    import kmp_pkg::*;

    logic [7:0]       m_store [MAX_PATTERN];
    logic [LEN_W-1:0] m_fail  [MAX_PATTERN + 1];

    logic [LEN_W-1:0] r_plen;
    logic [LEN_W-1:0] r_match;
    logic             r_found;
    logic             r_ovf;
    logic             r_is_text;
    logic [7:0]       r_ch;
    logic [LEN_W-1:0] r_i;
    logic [LEN_W-1:0] r_j;
    logic [7:0]       r_store_q;
    logic [LEN_W-1:0] r_fail_q;
    logic             r_out_valid;
    t_out_item        r_out;

    logic [LEN_W-1:0] eff_len;
    logic             full;
    logic [LEN_W-1:0] j_raw;
    logic [LEN_W-1:0] j_start;
    logic             is_pat_in;
    logic             hit;
    logic [LEN_W-1:0] j_next;
    logic [LEN_W-1:0] rd_addr;
    logic             fail_we;
    logic [LEN_W-1:0] fail_wa;
    logic [LEN_W-1:0] fail_wd;
    logic             store_we;

    assign is_pat_in = (i_in_data.cmd == CMD_PATTERN);
    assign eff_len   = i_in_data.first ? '0 : r_plen;
    assign full      = (eff_len >= LEN_W'(MAX_PATTERN));
    assign j_raw     = i_in_data.first ? '0 : r_match;
    assign j_start   = (j_raw > r_plen) ? '0 : j_raw;

    assign hit    = (r_ch == r_store_q);
    assign j_next = r_j + LEN_W'(hit);

    always_comb begin
        o_status.out_free = !r_out_valid || !i_out_stall;
        o_status.early    = is_pat_in ? (full || (eff_len == '0)) : (r_plen == '0);
        // During a walk: keep following links. At accept: a pattern byte needs a seed.
        if (i_cmd.accept) begin
            o_status.cont = is_pat_in;
        end else begin
            o_status.cont = (r_j != '0) &&
                            ((r_is_text && (r_j == r_plen)) || !hit);
        end
    end

    assign rd_addr = i_cmd.accept ? (is_pat_in ? eff_len : j_start) : r_fail_q;

    assign store_we = i_cmd.accept && is_pat_in && !full;

    always_comb begin
        fail_we = 1'b0;
        fail_wa = LEN_W'(1);
        fail_wd = '0;
        if (i_cmd.accept && is_pat_in && !full && (eff_len == '0)) begin
            fail_we = 1'b1;
        end else if (i_cmd.finish && !r_is_text) begin
            fail_we = 1'b1;
            fail_wa = r_i + LEN_W'(1);
            fail_wd = hit ? j_next : '0;
        end
    end

    // Memories: one write and one registered read each per cycle.
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            m_store[eff_len[SW-1:0]] <= i_in_data.ch;
        end
        r_store_q <= m_store[rd_addr[SW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (fail_we) begin
            m_fail[fail_wa] <= fail_wd;
        end
        r_fail_q <= m_fail[rd_addr];
    end

    // Item payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_ch      <= i_in_data.ch;
            r_is_text <= (i_in_data.cmd == CMD_TEXT);
            r_i       <= eff_len;
            r_j       <= j_start;
        end else if (i_cmd.seed || i_cmd.step) begin
            r_j <= r_fail_q;
        end
    end

    // Match state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen  <= '0;
            r_match <= '0;
            r_found <= 1'b0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.accept) begin
            if (is_pat_in) begin
                r_match <= '0;
                r_found <= 1'b0;
                r_ovf   <= full ? 1'b1 : (i_in_data.first ? 1'b0 : r_ovf);
                r_plen  <= (!full && (eff_len == '0)) ? LEN_W'(1) : eff_len;
            end else begin
                if (i_in_data.first || (r_plen == '0)) begin
                    r_match <= '0;
                end
                r_found <= (r_plen == '0) ? 1'b1 : (i_in_data.first ? 1'b0 : r_found);
            end
        end else if (i_cmd.finish) begin
            if (r_is_text) begin
                r_match <= j_next;
                if (j_next == r_plen) begin
                    r_found <= 1'b1;
                end
            end else begin
                r_plen <= r_i + LEN_W'(1);
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.found       <= r_found;
            r_out.matched_len <= r_is_text ? r_match : r_plen;
            r_out.too_long    <= r_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: rtl/core/kmp_substring_matcher_chk.sv
// ----------------------------------------------------------------------------
// kmp_substring_matcher_chk
// Port-level checks on the substring matcher, bound to its top level.
// ----------------------------------------------------------------------------
`include "kmp_substring_matcher_defines.svh"

module kmp_substring_matcher_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_stall,
    input kmp_pkg::t_in_item  i_in_data,
    input logic               i_out_valid,
    input logic               i_out_stall,
    input kmp_pkg::t_out_item i_out_data
);
    import kmp_pkg::*;

    logic in_fire;
    assign in_fire = i_in_valid && !i_in_stall;

    // A stalled result holds.
    `KMP_ASSERT_NEXT(a_out_hold, i_out_valid && i_out_stall, i_out_valid && $stable(i_out_data), "result changed while stalled")

    // One request at a time: the input closes right after an accept.
    `KMP_ASSERT_NEXT(a_one_at_a_time, in_fire, i_in_stall, "input open right after accept")

    // Lengths never pass the store size.
    `KMP_ASSERT_SAME(a_len_bound, i_out_valid, i_out_data.matched_len <= LEN_W'(MAX_PATTERN), "length beyond store size")

    // A result never shows in the cycle right after its accept: at the earliest,
    // the hand-off into the result register happens in that cycle.
    `KMP_ASSERT_NEXT(a_no_result_same_cycle, in_fire && !i_out_valid, !i_out_valid, "result before work done")

endmodule

bind kmp_substring_matcher kmp_substring_matcher_chk u_kmp_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);
